>>> hw/rtl/ribu_pkg.sv
// Types and constants shared by the regime interval blend unit.
// No dependencies; imported by every module of the block.
package ribu_pkg;

	localparam int CELL_COUNT   = 4096;
	localparam int CELL_AW      = 12;
	localparam int REGION_COUNT = 6;
	localparam int NUM_BOUNDS   = REGION_COUNT - 1;
	localparam int REGION_W     = 3;

	localparam logic [15:0] ONE_Q15  = 16'd32768;
	localparam logic [15:0] HALF_Q15 = 16'd16384;

	// Divider: 32 quotient bits, DIV_STEPS per stage.
	localparam int QUO_W      = 32;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;

	typedef enum logic [3:0] {
		REG_BOUND_1    = 4'd0,
		REG_BOUND_2    = 4'd1,
		REG_BOUND_3    = 4'd2,
		REG_BOUND_4    = 4'd3,
		REG_BOUND_5    = 4'd4,
		REG_BLEND_MASK = 4'd5,
		REG_BLEND_MODE = 4'd6,
		REG_RELAX      = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [CELL_AW-1:0] cell_index;
		logic signed [31:0] param_value;
	} in_item_t;

	typedef struct packed {
		logic [CELL_AW-1:0]  cell_out;
		logic [REGION_W-1:0] region;
		logic                is_blended;
		logic [15:0]         weight_lower;
		logic [15:0]         weight_upper;
	} out_item_t;

	// Sideband that travels with each item down the pipeline.
	typedef struct packed {
		logic [CELL_AW-1:0]  cell_id;
		logic [REGION_W-1:0] region;
		logic                blended;
		logic                quad;
		logic                lo_half;
		logic                dt_bad;
	} side_t;

endpackage

>>> hw/rtl/regime_interval_blend_unit.sv
// Regime interval blend unit: region search, pipelined divider and relaxation.
// Depends on ribu_pkg, ribu_div_stage and ribu_store.
//
// Usage: items enter on in_valid/in_ready (cell index and Q16.16 parameter), results
// leave on out_valid/out_ready, one result per item in order. Registers are
// written on cfg_valid/cfg_ready (always ready) by index; the user must write them
// only while the unit is idle; the unit itself does not enforce it. An item passes
// region search, two interval stages, eight divider stages of four quotient bits
// each, square, weight select, relax and output register. Throughput is one item
// per cycle while out_ready stays high; each stage advances whenever the stage after
// it is empty or moving, so bubbles close up and input is taken while a result waits
// at the output. When the receiver stalls, items pile up stage by stage and in_ready
// falls once the pipeline is full; nothing is lost or repeated.
// After reset the weight memory is swept to zero, one cell per cycle, and in_ready
// stays low until every cell is cleared; configuration writes are taken during it.
// A result's read-modify-write of the cell weight is forwarded to a directly
// following transaction on the same cell.
module regime_interval_blend_unit import ribu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration
	logic signed [31:0] bound_q [NUM_BOUNDS];
	logic [5:0]         mask_q;
	logic               mode_q;
	logic [15:0]        relax_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_BOUNDS; k++) begin
				bound_q[k] <= 32'(k) <<< 16;
			end
			mask_q  <= '0;
			mode_q  <= 1'b0;
			relax_q <= ONE_Q15;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BOUND_1:    bound_q[0] <= cfg_data;
				REG_BOUND_2:    bound_q[1] <= cfg_data;
				REG_BOUND_3:    bound_q[2] <= cfg_data;
				REG_BOUND_4:    bound_q[3] <= cfg_data;
				REG_BOUND_5:    bound_q[4] <= cfg_data;
				REG_BLEND_MASK: mask_q  <= cfg_data[5:0];
				REG_BLEND_MODE: mode_q  <= cfg_data[0];
				REG_RELAX:      relax_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage enables, back to front
	logic clearing;
	logic en_o, en_r, en_w, en_sq, en_s3, en_s2, en_s1;
	logic v_o, v_r, v_w, v_sq, v_s3, v_s2, v_s1;
	logic               v_d   [DIV_STAGES+1];
	logic               en_d  [DIV_STAGES+1];
	logic [32:0]        rem_d [DIV_STAGES+1];
	logic [31:0]        div_d [DIV_STAGES+1];
	logic [QUO_W-1:0]   quo_d [DIV_STAGES+1];
	side_t              side_d [DIV_STAGES+1];

	assign en_o  = !v_o || out_ready;
	assign en_r  = !v_r || en_o;
	assign en_w  = !v_w || en_r;
	assign en_sq = !v_sq || en_w;
	assign en_d[DIV_STAGES] = !v_d[DIV_STAGES] || en_sq;
	for (genvar g = 1; g < DIV_STAGES; g++) begin : g_en
		assign en_d[g] = !v_d[g] || en_d[g+1];
	end
	assign en_d[0] = en_s3;
	assign en_s3 = !v_s3 || en_d[1];
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1 && !clearing;

	// stage 1: region search
	logic [REGION_W-1:0] cnt_c;
	logic signed [31:0]  t0_c, t1_c;
	logic                blended_c;

	always_comb begin
		cnt_c = '0;
		for (int k = 0; k < NUM_BOUNDS; k++) begin
			if (bound_q[k] <= in_data.param_value) begin
				cnt_c = cnt_c + 1'b1;
			end
		end
		t0_c = '0;
		t1_c = '0;
		for (int k = 1; k < NUM_BOUNDS; k++) begin
			if (cnt_c == REGION_W'(k)) begin
				t0_c = bound_q[k-1];
				t1_c = bound_q[k];
			end
		end
		blended_c = (cnt_c >= REGION_W'(1)) && (cnt_c <= REGION_W'(REGION_COUNT - 2))
			&& mask_q[cnt_c];
	end

	logic [CELL_AW-1:0]  cell_s1, cell_s2;
	logic [REGION_W-1:0] region_s1, region_s2;
	logic                blended_s1, blended_s2;
	logic signed [31:0]  p_s1, t0_s1, t1_s1;
	logic signed [32:0]  dt_s2, a_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid && in_ready;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cell_s1    <= in_data.cell_index;
			region_s1  <= cnt_c;
			blended_s1 <= blended_c;
			p_s1       <= in_data.param_value;
			t0_s1      <= t0_c;
			t1_s1      <= t1_c;
		end
		if (en_s2) begin
			cell_s2    <= cell_s1;
			region_s2  <= region_s1;
			blended_s2 <= blended_s1;
			dt_s2      <= {t1_s1[31], t1_s1} - {t0_s1[31], t0_s1};
			a_s2       <= {p_s1[31], p_s1} - {t0_s1[31], t0_s1};
		end
	end

	// stage 3: clamp and pick the numerator
	logic        dt_bad_c, lo_half_c;
	logic [31:0] a_cl_c, b_c, x_c, udt_c;

	always_comb begin
		udt_c    = dt_s2[31:0];
		dt_bad_c = dt_s2[32] || (dt_s2 == '0);
		if (a_s2[32]) begin
			a_cl_c = '0;
		end else if (a_s2 > dt_s2) begin
			a_cl_c = udt_c;
		end else begin
			a_cl_c = a_s2[31:0];
		end
		b_c       = udt_c - a_cl_c;
		lo_half_c = {a_cl_c, 1'b0} <= {1'b0, udt_c};
		x_c       = (mode_q && lo_half_c) ? a_cl_c : b_c;
	end

	logic [32:0]      rem_s3;
	logic [31:0]      div_s3;
	side_t            side_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rem_s3          <= {1'b0, x_c};
			div_s3          <= dt_bad_c ? 32'd1 : udt_c;
			side_s3.cell_id <= cell_s2;
			side_s3.region  <= region_s2;
			side_s3.blended <= blended_s2;
			side_s3.quad    <= mode_q;
			side_s3.lo_half <= lo_half_c;
			side_s3.dt_bad  <= dt_bad_c;
		end
	end

	assign v_d[0]    = v_s3;
	assign rem_d[0]  = rem_s3;
	assign div_d[0]  = div_s3;
	assign quo_d[0]  = '0;
	assign side_d[0] = side_s3;

	// quotient = floor(x * 2^31 / dt)
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		ribu_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en_d[g+1]),
			.in_valid  (v_d[g]),
			.in_rem    (rem_d[g]),
			.in_div    (div_d[g]),
			.in_quo    (quo_d[g]),
			.in_side   (side_d[g]),
			.out_valid (v_d[g+1]),
			.out_rem   (rem_d[g+1]),
			.out_div   (div_d[g+1]),
			.out_quo   (quo_d[g+1]),
			.out_side  (side_d[g+1])
		);
	end

	// square and weight select
	logic [61:0] sq_sq;
	logic [15:0] lin_sq;
	side_t       side_sq, side_w, side_r;
	logic [15:0] w_w;
	logic [16:0] sqh_c;
	logic [15:0] w_c;

	always_comb begin
		sqh_c = sq_sq[60:44];
		if (side_sq.dt_bad) begin
			w_c = '0;
		end else if (!side_sq.quad) begin
			w_c = lin_sq;
		end else if (side_sq.lo_half) begin
			w_c = ONE_Q15 - sqh_c[15:0];
		end else begin
			w_c = sqh_c[15:0];
		end
	end

	// relaxation against the stored weight
	logic [15:0] w_r;
	logic [15:0] rd_data;
	logic        fwd_hit_q;
	logic [15:0] fwd_val_q;
	logic [15:0] old_c, f_c, c_c;
	logic [32:0] acc_c;
	logic        wr_c, hit_c;

	always_comb begin
		old_c = fwd_hit_q ? fwd_val_q : rd_data;
		f_c   = (relax_q > ONE_Q15) ? ONE_Q15 : relax_q;
		acc_c = 33'(f_c) * 33'(w_r) + 33'(ONE_Q15 - f_c) * 33'(old_c) + 33'(HALF_Q15);
		c_c   = (acc_c[32:15] > 18'(ONE_Q15)) ? ONE_Q15 : acc_c[30:15];
	end

	assign wr_c  = v_r && en_o && side_r.blended;
	assign hit_c = wr_c && (side_r.cell_id == side_w.cell_id);

	ribu_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.rd_en    (en_r && v_w),
		.rd_addr  (side_w.cell_id),
		.rd_data  (rd_data),
		.wr_en    (wr_c),
		.wr_addr  (side_r.cell_id),
		.wr_data  (c_c)
	);

	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq      <= 1'b0;
			v_w       <= 1'b0;
			v_r       <= 1'b0;
			v_o       <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (en_sq) v_sq <= v_d[DIV_STAGES];
			if (en_w)  v_w  <= v_sq;
			if (en_r) begin
				v_r       <= v_w;
				fwd_hit_q <= v_w && hit_c;
			end
			if (en_o)  v_o  <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en_sq) begin
			sq_sq   <= 62'(quo_d[DIV_STAGES][31:1]) * 62'(quo_d[DIV_STAGES][31:1]);
			lin_sq  <= quo_d[DIV_STAGES][31:16];
			side_sq <= side_d[DIV_STAGES];
		end
		if (en_w) begin
			w_w    <= w_c;
			side_w <= side_sq;
		end
		if (en_r) begin
			w_r       <= w_w;
			side_r    <= side_w;
			fwd_val_q <= c_c;
		end
		if (en_o) begin
			out_q.cell_out     <= side_r.cell_id;
			out_q.region       <= side_r.region;
			out_q.is_blended   <= side_r.blended;
			out_q.weight_lower <= side_r.blended ? c_c : 16'd0;
			out_q.weight_upper <= side_r.blended ? (ONE_Q15 - c_c) : 16'd0;
		end
	end

	assign out_valid = v_o;
	assign out_data  = out_q;

	// no transaction enters while the memory sweep runs
	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !in_ready)
		else $error("input accepted during weight clear");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_blended |->
			(17'(out_data.weight_lower) + 17'(out_data.weight_upper)) == 17'(ONE_Q15))
		else $error("blend weights do not sum to one");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_blended |->
			out_data.weight_lower == 16'd0 && out_data.weight_upper == 16'd0)
		else $error("weights set on unblended region");

	assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit_q |-> v_r)
		else $error("forwarded weight with empty relax stage");

endmodule

>>> hw/rtl/ribu_div_stage.sv
// One stage of the pipelined restoring divider: DIV_STEPS quotient bits.
// Depends on ribu_pkg.
module ribu_div_stage import ribu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [32:0]      in_rem,
	input  logic [31:0]      in_div,
	input  logic [QUO_W-1:0] in_quo,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [32:0]      out_rem,
	output logic [31:0]      out_div,
	output logic [QUO_W-1:0] out_quo,
	output side_t            out_side
);

	logic [32:0]      rem_c;
	logic [QUO_W-1:0] quo_c;
	logic             bit_c;

	// remainder stays below the divisor after each subtract, so the shift fits 33 bits
	always_comb begin
		rem_c = in_rem;
		quo_c = in_quo;
		bit_c = 1'b0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			bit_c = (rem_c >= {1'b0, in_div});
			if (bit_c) begin
				rem_c = rem_c - {1'b0, in_div};
			end
			rem_c = {rem_c[31:0], 1'b0};
			quo_c = {quo_c[QUO_W-2:0], bit_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem  <= rem_c;
			out_div  <= in_div;
			out_quo  <= quo_c;
			out_side <= in_side;
		end
	end

endmodule

>>> hw/rtl/ribu_store.sv
// Per-cell weight memory with a clearing sweep after reset.
// Depends on ribu_pkg.
module ribu_store import ribu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	output logic               clearing,
	input  logic               rd_en,
	input  logic [CELL_AW-1:0] rd_addr,
	output logic [15:0]        rd_data,
	input  logic               wr_en,
	input  logic [CELL_AW-1:0] wr_addr,
	input  logic [15:0]        wr_data
);

	logic [15:0]        mem [CELL_COUNT];
	logic               clearing_q;
	logic [CELL_AW-1:0] clr_addr_q;
	logic               we;
	logic [CELL_AW-1:0] wa;
	logic [15:0]        wd;

	assign clearing = clearing_q;
	assign we = clearing_q || wr_en;
	assign wa = clearing_q ? clr_addr_q : wr_addr;
	assign wd = clearing_q ? 16'd0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == CELL_AW'(CELL_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> test/tb_top.sv
// Testbench for regime_interval_blend_unit: directed, random and back-pressure tests.
// Depends on ribu_pkg and the unit itself; results are checked against an in-bench predictor.
`timescale 1ns / 100ps

module tb_top;
	import ribu_pkg::*;

	localparam logic [3:0] REG_SPARE = 4'd12;  // no register behind this index
	localparam int         SETTLE    = 20;     // idle cycles after the last result is checked

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor copy of the registers and the per-cell weights
	logic signed [31:0] bounds [NUM_BOUNDS];
	logic [5:0]         mask_q;
	logic               quad_q;
	logic [15:0]        relax_q;
	logic [15:0]        cell_weight [CELL_COUNT];

	out_item_t pending_results [$];
	int        errors;
	int        send_idle_pct;
	int        stall_pct;
	int        hold_cycles;

	regime_interval_blend_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("regime_interval_blend_unit test failed");
		$finish;
	end

	function automatic logic [15:0] raw_blend_weight(longint t0, longint t1, longint p);
		longint          dt;
		longint          a;
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned udt;
		longint unsigned r;
		dt = t1 - t0;
		a  = p - t0;
		if (dt <= 0)
			return 16'd0;
		if (a < 0)
			a = 0;
		if (a > dt)
			a = dt;
		udt = dt;
		ua  = a;
		ub  = udt - ua;
		if (!quad_q)
			return 16'((ub << 15) / udt);
		if (2 * ua <= udt) begin
			r = (ua << 30) / udt;
			return 16'(32'd32768 - 32'((2 * r * r) >> 45));
		end
		r = (ub << 30) / udt;
		return 16'((2 * r * r) >> 45);
	endfunction

	// region lookup, blend and relaxation; updates the weight copy
	function automatic out_item_t predict_blend(in_item_t it);
		out_item_t       res;
		int              region;
		logic [15:0]     w;
		longint unsigned f;
		longint unsigned acc;
		longint unsigned c;
		region = 0;
		for (int k = 0; k < NUM_BOUNDS; k++)
			if (bounds[k] <= it.param_value)
				region++;
		res              = '0;
		res.cell_out     = it.cell_index;
		res.region       = REGION_W'(region);
		res.is_blended   = region >= 1 && region + 2 <= REGION_COUNT && mask_q[region];
		if (res.is_blended) begin
			w   = raw_blend_weight(bounds[region-1], bounds[region], it.param_value);
			f   = relax_q > ONE_Q15 ? ONE_Q15 : relax_q;
			acc = f * w + (32768 - f) * cell_weight[it.cell_index] + 16384;
			c   = acc >> 15;
			if (c > 32768)
				c = 32768;
			cell_weight[it.cell_index] = 16'(c);
			res.weight_lower = 16'(c);
			res.weight_upper = 16'(32768 - c);
		end
		return res;
	endfunction

	task automatic write_reg(logic [3:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BOUND_1, REG_BOUND_2, REG_BOUND_3, REG_BOUND_4, REG_BOUND_5: begin
				bounds[idx] = val;
			end
			REG_BLEND_MASK: mask_q  = val[5:0];
			REG_BLEND_MODE: quad_q  = val[0];
			REG_RELAX:      relax_q = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_cell(logic [11:0] cell_id, logic [31:0] p);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid           <= 1'b1;
		in_data.cell_index <= cell_id;
		in_data.param_value <= p;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_blend('{cell_index: cell_id, param_value: p}));
		@(negedge clk);
	endtask

	// called at a falling edge, straight after the last send
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_bounds(int b1, int b2, int b3, int b4, int b5);
		write_reg(REG_BOUND_1, b1);
		write_reg(REG_BOUND_2, b2);
		write_reg(REG_BOUND_3, b3);
		write_reg(REG_BOUND_4, b4);
		write_reg(REG_BOUND_5, b5);
	endtask

	task automatic report(string field, int unsigned exp_v, int unsigned act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, out_data);
			end else begin
				out_item_t exp_r;
				exp_r = pending_results.pop_front();
				report("cell_out", exp_r.cell_out, out_data.cell_out);
				report("region", exp_r.region, out_data.region);
				report("is_blended", exp_r.is_blended, out_data.is_blended);
				report("weight_lower", exp_r.weight_lower, out_data.weight_lower);
				report("weight_upper", exp_r.weight_upper, out_data.weight_upper);
			end
		end
	end

	// receiver: a counted hold-off takes priority over random stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic test_directed;
		// reset bounds 0..4, interpolate inner regions, no relaxation
		write_reg(REG_BLEND_MASK, 32'h0000_003f);
		send_cell(12'd0, 32'h8000_0000);
		send_cell(12'd4095, 32'h7fff_ffff);
		send_cell(12'd1, 32'h0000_0000);
		send_cell(12'd2, 32'h0000_8000);
		send_cell(12'd3, 32'h0000_ffff);
		send_cell(12'd4, 32'h0001_4000);
		send_cell(12'd5, 32'h0003_c000);
		send_cell(12'd6, 32'h0004_0000);
		drain();
		write_reg(REG_BLEND_MODE, 32'd1);
		send_cell(12'd7, 32'h0000_4000);
		send_cell(12'd8, 32'h0000_8000);
		send_cell(12'd9, 32'h0000_c000);
		send_cell(12'd10, 32'h0002_0001);
		drain();
		// slow relaxation, same cell back to back
		write_reg(REG_RELAX, 32'd1000);
		send_cell(12'd11, 32'h0000_1000);
		send_cell(12'd11, 32'h0000_1000);
		send_cell(12'd11, 32'h0000_f000);
		drain();
		// factor above one, zero factor, spare index ignored
		write_reg(REG_RELAX, 32'h0000_ffff);
		write_reg(REG_SPARE, 32'hffff_ffff);
		send_cell(12'd12, 32'h0001_8000);
		drain();
		write_reg(REG_RELAX, 32'd0);
		send_cell(12'd12, 32'h0000_2000);
		drain();
		// unsorted bounds: empty interval and parameter outside its interval
		write_reg(REG_RELAX, 32'd32768);
		set_bounds(32'h0002_0000, 32'h0002_0000, 32'h0000_0000, 32'h0005_0000, 32'h0001_0000);
		send_cell(12'd13, 32'h0002_0000);
		send_cell(12'd14, 32'h0003_0000);
		send_cell(12'd15, 32'h0001_8000);
		drain();
	endtask

	task automatic random_config;
		int b [NUM_BOUNDS];
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) begin
			b = '{32'h8000_0000, -1000, 0, 1000, 32'h7fff_ffff};
		end else begin
			foreach (b[k])
				b[k] = (sel < 4) ? $urandom : $urandom_range(0, 20 * 65536) - 10 * 65536;
			if (sel != 9)
				b.sort();
		end
		set_bounds(b[0], b[1], b[2], b[3], b[4]);
		write_reg(REG_BLEND_MASK, $urandom);
		write_reg(REG_BLEND_MODE, $urandom);
		case ($urandom_range(3))
			0:       write_reg(REG_RELAX, 32'd32768);
			1:       write_reg(REG_RELAX, $urandom_range(0, 3) == 0 ? 32'd0 : 32'hffff);
			default: write_reg(REG_RELAX, $urandom);
		endcase
	endtask

	task automatic random_items(int count);
		logic [11:0] cell_id;
		logic [31:0] p;
		int          k;
		for (int n = 0; n < count; n++) begin
			cell_id = ($urandom_range(2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
			k       = $urandom_range(0, NUM_BOUNDS - 1);
			case ($urandom_range(3))
				0:       p = $urandom;
				1:       p = bounds[k] + $urandom_range(0, 8) - 4;
				default: p = bounds[k] + $urandom_range(0, 1 << 18) - (1 << 17);
			endcase
			send_cell(cell_id, p);
		end
	endtask

	task automatic test_random;
		int pcts [4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{31, 31}};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = pcts[ph][0];
			stall_pct     = pcts[ph][1];
			for (int s = 0; s < 6; s++) begin
				random_config();
				random_items(60);
				drain();
			end
		end
	endtask

	task automatic test_pressure;
		send_idle_pct = 0;
		stall_pct     = 0;
		random_config();
		@(negedge clk);
		hold_cycles = 200;
		random_items(60);
		drain();
		stall_pct = 20;
		random_items(40);
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_BOUND_1;
		cfg_data      = '0;
		errors        = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_cycles   = 0;
		for (int k = 0; k < NUM_BOUNDS; k++)
			bounds[k] = k * 65536;
		mask_q  = '0;
		quad_q  = 1'b0;
		relax_q = ONE_Q15;
		foreach (cell_weight[k])
			cell_weight[k] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random();
		test_pressure();

		if (errors == 0)
			$display("regime_interval_blend_unit test passed");
		else
			$display("regime_interval_blend_unit test failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/ribu_pkg.sv
hw/rtl/ribu_div_stage.sv
hw/rtl/ribu_store.sv
hw/rtl/regime_interval_blend_unit.sv
test/tb_top.sv
